>>> hw/rtl/tgbc_pkg.sv
// Shared types and constants for the two-group box collision scanner.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package tgbc_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_MOVE   = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // Actor types that matter to the tables.
  localparam logic [2:0] ACTOR_UNKNOWN     = 3'd0;
  localparam logic [2:0] ACTOR_PLAYER      = 3'd1;
  localparam logic [2:0] ACTOR_PLAYER_FIRE = 3'd2;

  // Result status codes.
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_NO_HIT    = 3'd1;
  localparam logic [2:0] STATUS_FULL      = 3'd2;
  localparam logic [2:0] STATUS_UNKNOWN   = 3'd3;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

  // Hits reported per tick, at most.
  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned CNT_W      = $clog2(RESULT_CAP + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted word and clear scan state
    logic update;  // apply a table update and load its result
    logic step;    // test one player/enemy pair
    logic finish;  // emit the closing result of a tick
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a word this cycle
    logic hit;         // current pair collides
    logic pend_valid;  // a hit is held back waiting for its successor
    logic scan_end;    // current pair is the last one
    logic cap_hit;     // current hit is the last one that may be reported
  } ctl_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/tgbc_ctrl.sv
// Controller state machine of the collision scanner.
// Depends on tgbc_pkg; drives the datapath only through command and status structs.
`default_nettype none
module tgbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_is_tick,
  output logic                in_ready,
  input  tgbc_pkg::ctl_stat_t stat,
  output tgbc_pkg::ctl_cmd_t  cmd
);
  import tgbc_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       step_ok;

  // A hit while another is held needs the output register to move the held one out.
  assign step_ok = !(stat.hit && stat.pend_valid) || stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = in_is_tick ? ST_SCAN : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (step_ok && (stat.scan_end || stat.cap_hit)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_UPDATE: cmd.update = stat.out_free;
      ST_SCAN:   cmd.step   = step_ok;
      ST_FINISH: cmd.finish = stat.out_free;
      default: ;
    endcase
  end

  // Only one datapath command may be active in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.update, cmd.step, cmd.finish}))
    else $error("more than one datapath command active");

  // A tick scan that reaches its last pair always moves to the finishing state.
  a_scan_to_finish: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && stat.scan_end) |=> (state == ST_FINISH))
    else $error("scan did not close after its last pair");

  // The output register is never loaded over an untaken word.
  a_update_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.update || cmd.finish) |-> stat.out_free)
    else $error("result loaded while output register busy");

endmodule
`default_nettype wire

>>> hw/rtl/tgbc_datapath.sv
// Datapath of the collision scanner: entity tables, id match, pair test and output register.
// Depends on tgbc_pkg; sequenced by tgbc_ctrl.
`default_nettype none
module tgbc_datapath #(
  parameter int unsigned PLAYER_SLOTS = 4,
  parameter int unsigned ENEMY_SLOTS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  tgbc_pkg::ctl_cmd_t  cmd,
  output tgbc_pkg::ctl_stat_t stat,
  input  logic [1:0]          kind,
  input  logic [15:0]         entity_id,
  input  logic [2:0]          actor_type,
  input  logic [11:0]         pos_x,
  input  logic [11:0]         pos_y,
  input  logic [7:0]          half_size,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [15:0]         player_side_id,
  output logic [15:0]         enemy_side_id,
  output logic                fire_hit,
  output logic                last
);
  import tgbc_pkg::*;

  localparam int unsigned PW = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
  localparam int unsigned EW = (ENEMY_SLOTS > 1) ? $clog2(ENEMY_SLOTS) : 1;

  // Captured word.
  logic [1:0]  kind_r;
  logic [15:0] id_r;
  logic [2:0]  type_r;
  logic [11:0] x_r;
  logic [11:0] y_r;
  logic [7:0]  hs_r;

  // Tables.
  logic [PLAYER_SLOTS-1:0] p_valid;
  logic [15:0]             p_id   [PLAYER_SLOTS];
  logic [11:0]             p_x    [PLAYER_SLOTS];
  logic [11:0]             p_y    [PLAYER_SLOTS];
  logic [7:0]              p_sz   [PLAYER_SLOTS];
  logic [PLAYER_SLOTS-1:0] p_fire;
  logic [ENEMY_SLOTS-1:0]  e_valid;
  logic [15:0]             e_id   [ENEMY_SLOTS];
  logic [11:0]             e_x    [ENEMY_SLOTS];
  logic [11:0]             e_y    [ENEMY_SLOTS];
  logic [7:0]              e_sz   [ENEMY_SLOTS];

  // Update logic.
  logic [PLAYER_SLOTS-1:0] pmatch, pv_after, p_valid_next, p_wr, p_mv;
  logic [ENEMY_SLOTS-1:0]  ematch, em_eff, ev_after, e_valid_next, e_wr, e_mv;
  logic                    p_free_found, e_free_found;
  logic [PW-1:0]           p_free_idx;
  logic [EW-1:0]           e_free_idx;
  logic                    add_bad, player_side, id_found;
  logic [2:0]              upd_status;

  // Scan state.
  logic [PW-1:0]    si;
  logic [EW-1:0]    sj;
  logic [CNT_W-1:0] hit_cnt;
  logic             pend_valid;
  logic [15:0]      pend_pid, pend_eid;
  logic             pend_fire;
  logic [7:0]       lim;
  logic [11:0]      dx, dy;
  logic             hit;

  // Output register load.
  logic        out_load;
  logic [2:0]  status_next;
  logic [15:0] pid_next, eid_next;
  logic        fire_next, last_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      id_r   <= entity_id;
      type_r <= actor_type;
      x_r    <= pos_x;
      y_r    <= pos_y;
      hs_r   <= half_size;
    end
  end

  // Id match over both tables; the player side wins when both match.
  always_comb begin
    for (int k = 0; k < PLAYER_SLOTS; k++) begin
      pmatch[k] = p_valid[k] && (p_id[k] == id_r);
    end
    for (int k = 0; k < ENEMY_SLOTS; k++) begin
      ematch[k] = e_valid[k] && (e_id[k] == id_r);
    end
  end

  assign em_eff      = (|pmatch) ? '0 : ematch;
  assign pv_after    = p_valid & ~pmatch;
  assign ev_after    = e_valid & ~em_eff;
  assign add_bad     = (type_r == ACTOR_UNKNOWN) || (id_r == 16'd0);
  assign player_side = (type_r == ACTOR_PLAYER) || (type_r == ACTOR_PLAYER_FIRE);
  assign id_found    = (id_r != 16'd0) && ((|pmatch) || (|ematch));

  // Lowest free slot after the old copy of the id is dropped.
  always_comb begin
    p_free_found = 1'b0;
    p_free_idx   = '0;
    for (int k = PLAYER_SLOTS - 1; k >= 0; k--) begin
      if (!pv_after[k]) begin
        p_free_found = 1'b1;
        p_free_idx   = PW'(k);
      end
    end
  end

  always_comb begin
    e_free_found = 1'b0;
    e_free_idx   = '0;
    for (int k = ENEMY_SLOTS - 1; k >= 0; k--) begin
      if (!ev_after[k]) begin
        e_free_found = 1'b1;
        e_free_idx   = EW'(k);
      end
    end
  end

  always_comb begin
    p_valid_next = p_valid;
    e_valid_next = e_valid;
    p_wr         = '0;
    e_wr         = '0;
    p_mv         = '0;
    e_mv         = '0;
    upd_status   = STATUS_OK;
    unique case (kind_r)
      KIND_ADD: begin
        if (add_bad) begin
          upd_status = STATUS_UNKNOWN;
        end else begin
          p_valid_next = pv_after;
          e_valid_next = ev_after;
          if (player_side) begin
            if (p_free_found) begin
              p_wr[p_free_idx]         = 1'b1;
              p_valid_next[p_free_idx] = 1'b1;
            end else begin
              upd_status = STATUS_FULL;
            end
          end else begin
            if (e_free_found) begin
              e_wr[e_free_idx]         = 1'b1;
              e_valid_next[e_free_idx] = 1'b1;
            end else begin
              upd_status = STATUS_FULL;
            end
          end
        end
      end
      KIND_REMOVE: begin
        if (!id_found) begin
          upd_status = STATUS_NOT_FOUND;
        end else begin
          p_valid_next = pv_after;
          e_valid_next = ev_after;
        end
      end
      KIND_MOVE: begin
        if (!id_found) begin
          upd_status = STATUS_NOT_FOUND;
        end else begin
          p_mv = pmatch;
          e_mv = em_eff;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= '0;
      e_valid <= '0;
    end else if (cmd.update) begin
      p_valid <= p_valid_next;
      e_valid <= e_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PLAYER_SLOTS; k++) begin
      if (cmd.update && p_wr[k]) begin
        p_id[k]   <= id_r;
        p_x[k]    <= x_r;
        p_y[k]    <= y_r;
        p_sz[k]   <= hs_r;
        p_fire[k] <= (type_r == ACTOR_PLAYER_FIRE);
      end else if (cmd.update && p_mv[k]) begin
        p_x[k] <= x_r;
        p_y[k] <= y_r;
      end
    end
    for (int k = 0; k < ENEMY_SLOTS; k++) begin
      if (cmd.update && e_wr[k]) begin
        e_id[k] <= id_r;
        e_x[k]  <= x_r;
        e_y[k]  <= y_r;
        e_sz[k] <= hs_r;
      end else if (cmd.update && e_mv[k]) begin
        e_x[k] <= x_r;
        e_y[k] <= y_r;
      end
    end
  end

  // Pair test for player slot si against enemy slot sj.
  assign lim = (p_sz[si] > e_sz[sj]) ? p_sz[si] : e_sz[sj];
  assign dx  = (p_x[si] >= e_x[sj]) ? (p_x[si] - e_x[sj]) : (e_x[sj] - p_x[si]);
  assign dy  = (p_y[si] >= e_y[sj]) ? (p_y[si] - e_y[sj]) : (e_y[sj] - p_y[si]);
  assign hit = p_valid[si] && e_valid[sj] &&
               (dx <= {4'd0, lim}) && (dy <= {4'd0, lim});

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      hit_cnt    <= '0;
      si         <= '0;
      sj         <= '0;
    end else if (cmd.load) begin
      pend_valid <= 1'b0;
      hit_cnt    <= '0;
      si         <= '0;
      sj         <= '0;
    end else if (cmd.step) begin
      if (sj == EW'(ENEMY_SLOTS - 1)) begin
        sj <= '0;
        si <= si + PW'(1);
      end else begin
        sj <= sj + EW'(1);
      end
      if (hit) begin
        pend_valid <= 1'b1;
        hit_cnt    <= hit_cnt + CNT_W'(1);
      end
    end else if (cmd.finish) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && hit) begin
      pend_pid  <= p_id[si];
      pend_eid  <= e_id[sj];
      pend_fire <= p_fire[si];
    end
  end

  always_comb begin
    out_load    = 1'b0;
    status_next = STATUS_OK;
    pid_next    = 16'd0;
    eid_next    = 16'd0;
    fire_next   = 1'b0;
    last_next   = 1'b1;
    priority if (cmd.update) begin
      out_load    = 1'b1;
      status_next = upd_status;
    end else if (cmd.step && hit && pend_valid) begin
      out_load  = 1'b1;
      pid_next  = pend_pid;
      eid_next  = pend_eid;
      fire_next = pend_fire;
      last_next = 1'b0;
    end else if (cmd.finish) begin
      out_load = 1'b1;
      if (pend_valid) begin
        pid_next  = pend_pid;
        eid_next  = pend_eid;
        fire_next = pend_fire;
      end else begin
        status_next = STATUS_NO_HIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= status_next;
      player_side_id <= pid_next;
      enemy_side_id  <= eid_next;
      fire_hit       <= fire_next;
      last           <= last_next;
    end
  end

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.hit        = hit;
  assign stat.pend_valid = pend_valid;
  assign stat.scan_end   = (si == PW'(PLAYER_SLOTS - 1)) && (sj == EW'(ENEMY_SLOTS - 1));
  assign stat.cap_hit    = hit && (hit_cnt == CNT_W'(RESULT_CAP - 1));

  // Ids stay unique across both tables, so a lookup finds at most one entry.
  a_id_unique_player: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pmatch))
    else $error("id present in more than one player slot");

  a_id_unique_both: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ematch) && !((|pmatch) && (|ematch)))
    else $error("id present more than once across the tables");

  // The hit count never runs past the report limit.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    hit_cnt <= CNT_W'(RESULT_CAP))
    else $error("hit count beyond report limit");

  // Every update produces exactly one loaded result.
  a_update_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> out_valid)
    else $error("update result not presented");

endmodule
`default_nettype wire

>>> hw/rtl/two_group_box_collision_scanner.sv
// Top level of the two-group box collision scanner.
// Instantiates tgbc_ctrl and tgbc_datapath; types come from tgbc_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------------
//   in      | into      | in_valid / in_ready  | kind, entity_id, actor_type, pos_x, pos_y,
//           |           |                      | half_size
//   out     | out of    | out_valid/ out_ready | status, player_side_id, enemy_side_id,
//           |           |                      | fire_hit, last
//
// An add, remove or move word is accepted in the idle state; once the output register
// is free, the update state looks up the id in both tables and writes the entry, and
// loads the result into the output register in the same cycle. A tick scans one
// player/enemy pair per cycle through a single box comparator, unless a hit must wait
// to replace a held one, and closes after its last pair or its RESULT_CAP-th hit.
// Reset (rst, synchronous) empties both tables at once through their valid bits. A
// held output word blocks only an update, a finish or a hit that must replace it; a new
// input word is taken as soon as the previous one is done, even if its result is still held.
`default_nettype none
module two_group_box_collision_scanner #(
  parameter int unsigned PLAYER_SLOTS = 4,
  parameter int unsigned ENEMY_SLOTS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] entity_id,
  input  logic [2:0]  actor_type,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [7:0]  half_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] player_side_id,
  output logic [15:0] enemy_side_id,
  output logic        fire_hit,
  output logic        last
);
  import tgbc_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      in_is_tick;

  // The controller picks its path from the kind of the word being accepted.
  assign in_is_tick = (kind == KIND_TICK);

  tgbc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_is_tick (in_is_tick),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds both tables, the pair comparator and the output register.
  tgbc_datapath #(
    .PLAYER_SLOTS (PLAYER_SLOTS),
    .ENEMY_SLOTS  (ENEMY_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (kind),
    .entity_id      (entity_id),
    .actor_type     (actor_type),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .half_size      (half_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .player_side_id (player_side_id),
    .enemy_side_id  (enemy_side_id),
    .fire_hit       (fire_hit),
    .last           (last)
  );

endmodule
`default_nettype wire
